// ===== sv/pic_pkg.sv =====
package pic_pkg;

    localparam int unsigned LEN_W = 7;
    localparam int unsigned INV_W = 10;
    localparam int unsigned CNT_W = 30;

    localparam logic [CNT_W-1:0] MODULUS = 30'd1000000007;

    typedef struct packed {
        logic             init_wr;
        logic             issue;
        logic             force_ws;
        logic             force_one;
        logic [INV_W-1:0] col;
        logic [LEN_W-1:0] row;
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_busy;
    } t_dp_stat;

endpackage

// ===== sv/pic_dp.sv =====
module pic_dp #(
    parameter int MAX_INV = 1023
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  pic_pkg::t_dp_cmd         i_cmd,
    output pic_pkg::t_dp_stat        o_stat,
    output logic [pic_pkg::CNT_W-1:0] o_count
);

    localparam int DEPTH = (MAX_INV > 1023) ? 1024 : MAX_INV + 1;
    localparam int AW    = $clog2(DEPTH);

    logic [pic_pkg::CNT_W-1:0] r_mem_even [DEPTH];
    logic [pic_pkg::CNT_W-1:0] r_mem_odd  [DEPTH];

    logic [pic_pkg::CNT_W-1:0] r_new_e, r_old_e, r_new_o, r_old_o;
    logic                      r_v_a, r_first_a, r_use_old_a;
    logic [AW-1:0]             r_addr_a;
    logic                      r_v_b, r_first_b;
    logic [AW-1:0]             r_addr_b;
    logic [pic_pkg::CNT_W-1:0] r_diff;
    logic [pic_pkg::CNT_W-1:0] r_ws;

    logic [AW-1:0]                w_addr_new, w_addr_old;
    logic [pic_pkg::INV_W-1:0]    w_col_back;
    logic [pic_pkg::CNT_W-1:0]    w_new, w_old, n_diff;
    logic [pic_pkg::CNT_W-1:0]    w_base, w_ws_next;
    logic [pic_pkg::CNT_W:0]      w_sum, w_wrap;
    logic                         w_wr_even, w_wr_odd;
    logic [AW-1:0]                w_wr_addr_e;
    logic [pic_pkg::CNT_W-1:0]    w_wr_data_e;

    // src is the even row when the current row is odd
    assign w_col_back = i_cmd.col - {3'b000, i_cmd.row};
    assign w_addr_new = i_cmd.col[AW-1:0];
    assign w_addr_old = w_col_back[AW-1:0];

    assign w_new = i_cmd.row[0] ? r_new_e : r_new_o;
    assign w_old = !r_use_old_a ? '0 : (i_cmd.row[0] ? r_old_e : r_old_o);

    always_comb begin
        if (w_new >= w_old) begin
            n_diff = w_new - w_old;
        end else begin
            n_diff = pic_pkg::CNT_W'({1'b0, w_new} + {1'b0, pic_pkg::MODULUS} - {1'b0, w_old});
        end
    end

    assign w_base    = r_first_b ? '0 : r_ws;
    assign w_sum     = {1'b0, w_base} + {1'b0, r_diff};
    assign w_wrap    = w_sum - {1'b0, pic_pkg::MODULUS};
    assign w_ws_next = (w_sum >= {1'b0, pic_pkg::MODULUS}) ? w_wrap[pic_pkg::CNT_W-1:0]
                                                            : w_sum[pic_pkg::CNT_W-1:0];

    assign w_wr_odd    = r_v_b && i_cmd.row[0];
    assign w_wr_even   = i_cmd.init_wr || (r_v_b && !i_cmd.row[0]);
    assign w_wr_addr_e = i_cmd.init_wr ? w_addr_new : r_addr_b;
    assign w_wr_data_e = i_cmd.init_wr ? ((i_cmd.col == '0) ? pic_pkg::CNT_W'(1) : '0)
                                       : w_ws_next;

    always_ff @(posedge i_clk) begin
        if (w_wr_even) begin
            r_mem_even[w_wr_addr_e] <= w_wr_data_e;
        end
        r_new_e <= r_mem_even[w_addr_new];
        r_old_e <= r_mem_even[w_addr_old];
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_odd) begin
            r_mem_odd[r_addr_b] <= w_ws_next;
        end
        r_new_o <= r_mem_odd[w_addr_new];
        r_old_o <= r_mem_odd[w_addr_old];
    end

    always_ff @(posedge i_clk) begin
        r_addr_a    <= w_addr_new;
        r_first_a   <= (i_cmd.col == '0);
        r_use_old_a <= (i_cmd.col >= {3'b000, i_cmd.row});
        r_addr_b    <= r_addr_a;
        r_first_b   <= r_first_a;
        r_diff      <= n_diff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_a <= 1'b0;
            r_v_b <= 1'b0;
            r_ws  <= '0;
        end else begin
            r_v_a <= i_cmd.issue;
            r_v_b <= r_v_a;
            if (i_cmd.force_ws) begin
                r_ws <= {{(pic_pkg::CNT_W-1){1'b0}}, i_cmd.force_one};
            end else if (r_v_b) begin
                r_ws <= w_ws_next;
            end
        end
    end

    assign o_stat.pipe_busy = r_v_a | r_v_b;
    assign o_count          = r_ws;

`ifndef SYNTH
    a_ws_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ws < pic_pkg::MODULUS)
        else $error("window sum not reduced");

    a_diff_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v_b |-> r_diff < pic_pkg::MODULUS)
        else $error("window difference not reduced");
`endif

endmodule

// ===== sv/pic_ctrl.sv =====
module pic_ctrl #(
    parameter int MAX_LEN = 64,
    parameter int MAX_INV = 1023
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [pic_pkg::LEN_W-1:0] i_length,
    input  logic [pic_pkg::INV_W-1:0] i_inversions,
    output logic                      o_valid,
    output pic_pkg::t_dp_cmd          o_cmd,
    input  pic_pkg::t_dp_stat         i_stat
);

    localparam int LEN_CAP = (MAX_LEN > 127) ? 127 : MAX_LEN;
    localparam logic [pic_pkg::LEN_W-1:0] LEN_LIM = pic_pkg::LEN_W'(LEN_CAP);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_INIT  = 5'b00010,
        S_ROW   = 5'b00100,
        S_DRAIN = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state                    r_state, n_state;
    logic [pic_pkg::LEN_W-1:0] r_len, n_len, r_row, n_row;
    logic [pic_pkg::INV_W-1:0] r_inv, n_inv, r_col, n_col;

    logic                      w_accept, w_inv_big, w_short;
    logic [pic_pkg::LEN_W-1:0] w_len;

    assign w_accept  = start && (r_state == S_IDLE);
    assign w_len     = (i_length > LEN_LIM) ? LEN_LIM : i_length;
    assign w_inv_big = {22'd0, i_inversions} > 32'(MAX_INV);
    assign w_short   = w_inv_big || (w_len == '0);

    always_comb begin
        n_state = r_state;
        n_len   = r_len;
        n_inv   = r_inv;
        n_row   = r_row;
        n_col   = r_col;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_len   = w_len;
                    n_inv   = i_inversions;
                    n_col   = '0;
                    n_state = w_short ? S_DONE : S_INIT;
                end
            end
            S_INIT: begin
                if (r_col == r_inv) begin
                    n_col   = '0;
                    n_row   = pic_pkg::LEN_W'(1);
                    n_state = S_ROW;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            S_ROW: begin
                if (r_col == r_inv) begin
                    n_state = S_DRAIN;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!i_stat.pipe_busy) begin
                    if (r_row == r_len) begin
                        n_state = S_DONE;
                    end else begin
                        n_row   = r_row + 1'b1;
                        n_col   = '0;
                        n_state = S_ROW;
                    end
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_len   <= '0;
            r_inv   <= '0;
            r_row   <= '0;
            r_col   <= '0;
        end else begin
            r_state <= n_state;
            r_len   <= n_len;
            r_inv   <= n_inv;
            r_row   <= n_row;
            r_col   <= n_col;
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

    assign o_cmd.init_wr   = (r_state == S_INIT);
    assign o_cmd.issue     = (r_state == S_ROW);
    assign o_cmd.force_ws  = w_accept && w_short;
    assign o_cmd.force_one = !w_inv_big && (i_inversions == '0);
    assign o_cmd.col       = r_col;
    assign o_cmd.row       = r_row;

`ifndef SYNTH
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("transaction accepted but block not busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !busy && !o_valid)
        else $error("result strobe longer than one cycle");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROW) |-> (r_row != '0) && (r_row <= r_len) && (r_col <= r_inv))
        else $error("row or column out of range");
`endif

endmodule

// ===== sv/permutation_inversion_counter.sv =====
// Channel   | Ports                             | Handshake
// query     | i_length, i_inversions            | start high while busy low
// result    | o_count                           | o_valid for one cycle
//
// A query of length n and k inversions walks one column of one row a cycle
// through the row stores, with a pipeline drain between rows.
// Zero length or k beyond the store depth answers without a row pass.
// Synchronous active-low reset returns the controller to idle; row stores
// are not cleared. The receiver cannot stall: o_count is valid with o_valid.
module permutation_inversion_counter #(
    parameter int MAX_LEN = 64,
    parameter int MAX_INV = 1023
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [pic_pkg::LEN_W-1:0] i_length,
    input  logic [pic_pkg::INV_W-1:0] i_inversions,
    output logic                      o_valid,
    output logic [pic_pkg::CNT_W-1:0] o_count
);

    pic_pkg::t_dp_cmd  w_cmd;
    pic_pkg::t_dp_stat w_stat;

    pic_ctrl #(
        .MAX_LEN(MAX_LEN),
        .MAX_INV(MAX_INV)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_length    (i_length),
        .i_inversions(i_inversions),
        .o_valid     (o_valid),
        .o_cmd       (w_cmd),
        .i_stat      (w_stat)
    );

    pic_dp #(
        .MAX_INV(MAX_INV)
    ) u_dp (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (w_cmd),
        .o_stat (w_stat),
        .o_count(o_count)
    );

endmodule
